// ----- rtl/core/fhp_pkg.sv -----
package fhp_pkg;

    // Frame layout
    localparam logic [5:0]  ETH_HEADER_BYTES = 6'd14;
    localparam logic [5:0]  ETYPE_HI_POS     = 6'd12;
    localparam logic [5:0]  ETYPE_LO_POS     = 6'd13;
    localparam logic [6:0]  IP_HEADER_BYTES  = 7'd20;
    localparam logic [6:0]  TCP_NEED_BYTES   = 7'd14;
    localparam logic [6:0]  UDP_NEED_BYTES   = 7'd4;
    localparam logic [5:0]  POSITION_MAX     = 6'd63;

    // Header field codes
    localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;

    // Header fields gathered while a frame streams in
    typedef struct packed {
        logic [15:0] link_type;
        logic [15:0] total_length;
        logic [15:0] identification;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [31:0] sequence_number;
        logic [7:0]  flag_bits;
        logic [3:0]  data_offset;
    } hdr_t;

    // One finished frame, handed from the front end to the back end
    typedef struct packed {
        logic        has_eth;
        logic [5:0]  last_pos;
        hdr_t        hdr;
    } frame_rec_t;

    // One result item
    typedef struct packed {
        logic        accepted;
        logic [7:0]  protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] identification;
        logic [7:0]  flag_bits;
        logic [31:0] sequence_number;
        logic [15:0] payload_length;
        logic [15:0] frame_length;
    } result_t;

endpackage

// ----- rtl/core/fhp_if.sv -----
interface fhp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fhp_result_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [7:0]  protocol;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [15:0] identification;
    logic [7:0]  flag_bits;
    logic [31:0] sequence_number;
    logic [15:0] payload_length;
    logic [15:0] frame_length;

    modport source (
        output valid, input ready,
        output accepted, output protocol, output source_address,
        output destination_address, output source_port, output destination_port,
        output identification, output flag_bits, output sequence_number,
        output payload_length, output frame_length
    );
    modport sink (
        input valid, output ready,
        input accepted, input protocol, input source_address,
        input destination_address, input source_port, input destination_port,
        input identification, input flag_bits, input sequence_number,
        input payload_length, input frame_length
    );
endinterface

// ----- rtl/core/fhp_front.sv -----
module fhp_front
    import fhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       has_eth,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       rec_push,
    output frame_rec_t rec_data,
    input  logic       rec_full
);

    logic [5:0] pos_reg;
    logic [5:0] pos_next;
    hdr_t       hdr_reg;
    hdr_t       hdr_next;
    hdr_t       hdr_cap;
    logic [5:0] base;
    logic [5:0] rel;
    logic       accept;

    assign in_ready = !rec_full;
    assign accept   = in_valid && in_ready;
    assign base     = has_eth ? ETH_HEADER_BYTES : 6'd0;
    assign rel      = pos_reg - base;

    // Header state with the current byte folded in
    always_comb
    begin
        hdr_cap = hdr_reg;
        if (has_eth && pos_reg == ETYPE_HI_POS)
        begin
            hdr_cap.link_type[15:8] = data_byte;
        end
        if (has_eth && pos_reg == ETYPE_LO_POS)
        begin
            hdr_cap.link_type[7:0] = data_byte;
        end
        if (pos_reg >= base)
        begin
            case (rel) inside
                6'd2:  hdr_cap.total_length[15:8]   = data_byte;
                6'd3:  hdr_cap.total_length[7:0]    = data_byte;
                6'd4:  hdr_cap.identification[15:8] = data_byte;
                6'd5:  hdr_cap.identification[7:0]  = data_byte;
                6'd9:  hdr_cap.protocol             = data_byte;
                [6'd12:6'd15]:
                    hdr_cap.source_address[{~rel[1:0], 3'b000} +: 8] = data_byte;
                [6'd16:6'd19]:
                    hdr_cap.destination_address[{~rel[1:0], 3'b000} +: 8] = data_byte;
                [6'd20:6'd21]:
                    hdr_cap.source_port[{~rel[0], 3'b000} +: 8] = data_byte;
                [6'd22:6'd23]:
                    hdr_cap.destination_port[{~rel[0], 3'b000} +: 8] = data_byte;
                [6'd24:6'd27]:
                    hdr_cap.sequence_number[{~rel[1:0], 3'b000} +: 8] = data_byte;
                6'd32: hdr_cap.data_offset          = data_byte[7:4];
                6'd33: hdr_cap.flag_bits            = data_byte;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        hdr_next = hdr_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                pos_next = '0;
                hdr_next = '0;
            end
            else
            begin
                hdr_next = hdr_cap;
                if (pos_reg != POSITION_MAX)
                begin
                    pos_next = pos_reg + 6'd1;
                end
            end
        end
    end

    assign rec_push          = accept && last_byte;
    assign rec_data.has_eth  = has_eth;
    assign rec_data.last_pos = pos_reg;
    assign rec_data.hdr      = hdr_cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hdr_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            hdr_reg <= hdr_next;
        end
    end

endmodule

// ----- rtl/core/fhp_queue.sv -----
module fhp_queue
    import fhp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_data,
    output logic       full,
    input  logic       pop,
    output frame_rec_t pop_data,
    output logic       not_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    frame_rec_t    slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = count_reg == CW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/fhp_back.sv -----
module fhp_back
    import fhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rec_valid,
    input  frame_rec_t rec_data,
    output logic       rec_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;
    result_t    result_next;
    logic       is_tcp;
    logic       is_udp;
    logic [6:0] count;
    logic [6:0] need;
    logic [6:0] base;
    logic       type_ok;
    logic       frame_ok;

    assign is_tcp  = rec_data.hdr.protocol == PROTO_TCP;
    assign is_udp  = rec_data.hdr.protocol == PROTO_UDP;
    assign base    = rec_data.has_eth ? {1'b0, ETH_HEADER_BYTES} : 7'd0;
    assign count   = {1'b0, rec_data.last_pos} + 7'd1;
    assign need    = base + IP_HEADER_BYTES + (is_tcp ? TCP_NEED_BYTES : UDP_NEED_BYTES);
    assign type_ok = !rec_data.has_eth || rec_data.hdr.link_type == ETHERTYPE_IPV4;
    assign frame_ok = (is_tcp || is_udp) && (count >= need) && type_ok;

    assign rec_pop = rec_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        result_next = '0;
        if (frame_ok)
        begin
            result_next.accepted            = 1'b1;
            result_next.protocol            = rec_data.hdr.protocol;
            result_next.source_address      = rec_data.hdr.source_address;
            result_next.destination_address = rec_data.hdr.destination_address;
            result_next.source_port         = rec_data.hdr.source_port;
            result_next.destination_port    = rec_data.hdr.destination_port;
            result_next.identification      = rec_data.hdr.identification;
            result_next.frame_length        = rec_data.hdr.total_length + {9'd0, base};
            if (is_tcp)
            begin
                result_next.flag_bits       = rec_data.hdr.flag_bits;
                result_next.sequence_number = rec_data.hdr.sequence_number;
                result_next.payload_length  = rec_data.hdr.total_length
                                              - {9'd0, IP_HEADER_BYTES}
                                              - {10'd0, rec_data.hdr.data_offset, 2'b00};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rec_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

endmodule

// ----- rtl/core/flow_header_parser.sv -----
// flow_header_parser: pulls the IPv4 five-tuple plus IP id, TCP flags, sequence
// number and lengths out of a frame streamed one byte per transfer.
// byte_in : one frame byte per transfer, last_byte marks the end of frame.
//           Ready drops only while the frame queue is full.
// result_out: one result per frame, with accepted = 1 for TCP/UDP frames
//           (EtherType IPv4 if an Ethernet header is on) whose headers arrived
//           in full; all other fields read 0 when the frame is refused.
// cfg_write_enable / cfg_write_data: has_ethernet_header (reset 1), written
//           at any clock edge with the enable high.
// Throughput: one byte per cycle while the frame queue is not full;
//           frames may follow each other directly.
// Result path: the frame enters the queue at the last-byte transfer, then
//           the result register loads from the queue and valid rises with it.
// Receiver stall: results wait in the output register and the queue
//           (QUEUE_DEPTH frames); bytes keep flowing until the queue fills.
// Reset: clears the byte position, captured header and queue pointers and count.
module flow_header_parser
    import fhp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_enable,
    input  logic                cfg_write_data,
    fhp_byte_if.sink            byte_in,
    fhp_result_if.source        result_out
);

    logic       has_eth_reg;
    logic       has_eth_next;
    logic       rec_push;
    frame_rec_t push_rec;
    logic       q_full;
    logic       q_not_empty;
    logic       rec_pop;
    frame_rec_t pop_rec;
    result_t    result;

    // Config register, takes effect on the next byte
    assign has_eth_next = cfg_write_enable ? cfg_write_data : has_eth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_eth_reg <= 1'b1;
        end
        else
        begin
            has_eth_reg <= has_eth_next;
        end
    end

    // Front end: byte position tracking and field capture
    fhp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .has_eth   (has_eth_reg),
        .in_valid  (byte_in.valid),
        .in_ready  (byte_in.ready),
        .data_byte (byte_in.data_byte),
        .last_byte (byte_in.last_byte),
        .rec_push  (rec_push),
        .rec_data  (push_rec),
        .rec_full  (q_full)
    );

    // Finished frames wait here so either side can stall
    fhp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (push_rec),
        .full      (q_full),
        .pop       (rec_pop),
        .pop_data  (pop_rec),
        .not_empty (q_not_empty)
    );

    // Back end: accept check, length math, output register
    fhp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_not_empty),
        .rec_data  (pop_rec),
        .rec_pop   (rec_pop),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_data  (result)
    );

    assign result_out.accepted            = result.accepted;
    assign result_out.protocol            = result.protocol;
    assign result_out.source_address      = result.source_address;
    assign result_out.destination_address = result.destination_address;
    assign result_out.source_port         = result.source_port;
    assign result_out.destination_port    = result.destination_port;
    assign result_out.identification      = result.identification;
    assign result_out.flag_bits           = result.flag_bits;
    assign result_out.sequence_number     = result.sequence_number;
    assign result_out.payload_length      = result.payload_length;
    assign result_out.frame_length        = result.frame_length;

endmodule
